// File: src/rhm_pkg.sv
package rhm_pkg;

   // pixel and register widths fixed by the interface
   localparam int PIX_W = 8;
   localparam int TH_W = 5;
   localparam logic [TH_W-1:0] TH_RESET = 5'd12;

   // window geometry
   localparam int RADIUS = 2;
   localparam int WIDTH = 2 * RADIUS + 1;
   localparam int AREA = WIDTH * WIDTH;
   localparam int CNT_W = $clog2(AREA + 1);
   localparam int COL_W = $clog2(WIDTH);
   localparam int SEEN_W = $clog2(RADIUS + 1);

   // default histogram size
   localparam int BINS_DEFAULT = 256;

   typedef enum logic [2:0] {
      RHM_INIT,
      RHM_IDLE,
      RHM_CLEAR,
      RHM_UPDATE,
      RHM_WALK_START,
      RHM_WALK_DOWN,
      RHM_WALK_UP,
      RHM_EMIT
   } rhm_state_type;

endpackage

// File: src/rhm_hist_ram.sv
module rhm_hist_ram #(
   parameter int DEPTH = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] q_ff;
   logic              fwd_ff;
   logic [DATA_W-1:0] fwd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // flag a read that collides with a write on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   // forward the fresh value over the stale array word
   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;

endmodule

// File: src/running_histogram_median_filter.sv
// Sliding 5x5 rank filter built on a running histogram. Each request word is one
// image column of five pixels plus a row-start flag; after two columns of a row
// the block returns the value that has rank_threshold smaller pixels in the window
// centered two columns back (12 gives the median, values above 24 give the
// maximum). The histogram sits in a single-port-read, single-port-write RAM of
// BINS counters with a registered read port. A plain column takes an accept
// step, one read-modify-write per pixel removed and per pixel added (remove the
// oldest column, add the new one), a step to start the rank walk, a walk step for
// each bin the rank value moves (plus a final check step when moving up) and a
// step to load the response register, which waits while the response slot is full;
// a warm-up column returns no word and skips that last step. A row-start column
// first purges the 25 window pixels back to bin zero through the same RAM.
// After reset the block runs a clearing pass over all BINS words of the RAM before
// it takes its first request word; csr writes are taken at any time.
module running_histogram_median_filter #(
   parameter int BINS = rhm_pkg::BINS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rhm_pkg::PIX_W-1:0] req_pix_0,
   input  logic [rhm_pkg::PIX_W-1:0] req_pix_1,
   input  logic [rhm_pkg::PIX_W-1:0] req_pix_2,
   input  logic [rhm_pkg::PIX_W-1:0] req_pix_3,
   input  logic [rhm_pkg::PIX_W-1:0] req_pix_4,
   input  logic                      req_row_start,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [rhm_pkg::PIX_W-1:0] rsp_median_out,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rhm_pkg::TH_W-1:0]  csr_wdata
);

   import rhm_pkg::*;

   localparam int BIN_W = $clog2(BINS);

   rhm_state_type state_ff, state_in;

   logic [BIN_W-1:0] init_addr_ff, init_addr_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] pix_ff, pix_in;
   logic             half_ff, half_in;
   logic             pend_ff, pend_in;
   logic [BIN_W-1:0] pend_addr_ff, pend_addr_in;
   logic             pend_inc_ff, pend_inc_in;
   logic [BIN_W-1:0] fresh_ff [WIDTH];
   logic [BIN_W-1:0] fresh_in [WIDTH];
   logic [BIN_W-1:0] col_hist_ff [WIDTH][WIDTH];
   logic [BIN_W-1:0] col_hist_in [WIDTH][WIDTH];
   logic [BIN_W-1:0] med_ff, med_in;
   logic [CNT_W-1:0] below_ff, below_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [TH_W-1:0]  th_ff, th_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_med_ff, rsp_med_in;

   logic             rd_en;
   logic [BIN_W-1:0] rd_addr;
   logic [CNT_W-1:0] rd_data;
   logic             wr_en;
   logic [BIN_W-1:0] wr_addr;
   logic [CNT_W-1:0] wr_data;

   logic [PIX_W-1:0] req_pix [WIDTH];
   logic             pix_last, col_last;
   logic             op_last_clr, op_last_upd;
   logic [BIN_W-1:0] op_addr;
   logic [CNT_W:0]   th_sat;
   logic             go_down;
   logic [BIN_W-1:0] med_dn;
   logic [CNT_W-1:0] below_dn;
   logic             dn_cont;
   logic [CNT_W:0]   up_sum;
   logic             up_cont;
   logic             walk_done;
   logic             slot_free;

   assign req_pix[0] = req_pix_0;
   assign req_pix[1] = req_pix_1;
   assign req_pix[2] = req_pix_2;
   assign req_pix[3] = req_pix_3;
   assign req_pix[4] = req_pix_4;

   // histogram RAM
   rhm_hist_ram #(
      .DEPTH  (BINS),
      .ADDR_W (BIN_W),
      .DATA_W (CNT_W)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // sequencing of the per-pixel bin updates
   assign pix_last = (pix_ff == COL_W'(WIDTH - 1));
   assign col_last = (col_ff == COL_W'(WIDTH - 1));
   assign op_last_clr = half_ff && pix_last && col_last;
   assign op_last_upd = half_ff && pix_last;

   // bin touched by the current update step
   always_comb begin
      if (!half_ff) begin
         op_addr = col_hist_ff[col_ff][pix_ff];
      end else if (state_ff == RHM_CLEAR) begin
         op_addr = '0;
      end else begin
         op_addr = fresh_ff[pix_ff];
      end
   end

   // rank walk arithmetic
   assign th_sat = ({1'b0, CNT_W'(th_ff)} > (CNT_W + 1)'(AREA - 1)) ?
                   (CNT_W + 1)'(AREA - 1) : {1'b0, CNT_W'(th_ff)};
   assign go_down = ({1'b0, below_ff} > th_sat);
   assign med_dn = med_ff - BIN_W'(1);
   assign below_dn = below_ff - rd_data;
   assign dn_cont = ({1'b0, below_dn} > th_sat) && (med_dn != '0);
   assign up_sum = {1'b0, below_ff} + {1'b0, rd_data};
   assign up_cont = (up_sum <= th_sat) && (med_ff != BIN_W'(BINS - 1));

   always_comb begin
      walk_done = 1'b0;
      unique case (state_ff)
         RHM_WALK_START: walk_done = go_down && (med_ff == '0);
         RHM_WALK_DOWN:  walk_done = !dn_cont;
         RHM_WALK_UP:    walk_done = !up_cont;
         default:        walk_done = 1'b0;
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RHM_INIT: begin
            if (init_addr_ff == BIN_W'(BINS - 1)) state_in = RHM_IDLE;
         end
         RHM_IDLE: begin
            if (req_valid) state_in = req_row_start ? RHM_CLEAR : RHM_UPDATE;
         end
         RHM_CLEAR: begin
            if (op_last_clr) state_in = RHM_UPDATE;
         end
         RHM_UPDATE: begin
            if (op_last_upd) state_in = RHM_WALK_START;
         end
         RHM_WALK_START: begin
            if (!go_down) state_in = RHM_WALK_UP;
            else if (med_ff != '0) state_in = RHM_WALK_DOWN;
         end
         RHM_WALK_DOWN, RHM_WALK_UP: begin
         end
         RHM_EMIT: begin
            if (slot_free) state_in = RHM_IDLE;
         end
         default: state_in = RHM_INIT;
      endcase
      if (walk_done) begin
         state_in = (seen_ff == SEEN_W'(RADIUS)) ? RHM_EMIT : RHM_IDLE;
      end
   end

   // datapath and RAM control
   always_comb begin
      init_addr_in = init_addr_ff;
      col_in = col_ff;
      pix_in = pix_ff;
      half_in = half_ff;
      pend_in = 1'b0;
      pend_addr_in = pend_addr_ff;
      pend_inc_in = pend_inc_ff;
      fresh_in = fresh_ff;
      col_hist_in = col_hist_ff;
      med_in = med_ff;
      below_in = below_ff;
      seen_in = seen_ff;
      th_in = th_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_med_in = rsp_med_ff;
      rd_en = 1'b0;
      rd_addr = '0;

      // finish the pending read-modify-write, or sweep after reset
      if (state_ff == RHM_INIT) begin
         wr_en = 1'b1;
         wr_addr = init_addr_ff;
         wr_data = (init_addr_ff == '0) ? CNT_W'(AREA) : '0;
      end else begin
         wr_en = pend_ff;
         wr_addr = pend_addr_ff;
         wr_data = pend_inc_ff ? (rd_data + CNT_W'(1)) : (rd_data - CNT_W'(1));
      end

      // drop the word once taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (csr_valid) th_in = csr_wdata;

      unique case (state_ff)
         RHM_INIT: begin
            init_addr_in = init_addr_ff + BIN_W'(1);
         end
         RHM_IDLE: begin
            // capture the column, saturated to the histogram range
            if (req_valid) begin
               for (int k = 0; k < WIDTH; k++) begin
                  if (32'(req_pix[k]) > 32'(BINS - 1)) begin
                     fresh_in[k] = BIN_W'(BINS - 1);
                  end else begin
                     fresh_in[k] = BIN_W'(req_pix[k]);
                  end
               end
            end
         end
         RHM_CLEAR, RHM_UPDATE: begin
            // issue the read for this step, write it back next cycle
            rd_en = 1'b1;
            rd_addr = op_addr;
            pend_in = 1'b1;
            pend_addr_in = op_addr;
            pend_inc_in = half_ff;
            half_in = !half_ff;
            if (half_ff) begin
               pix_in = pix_last ? '0 : pix_ff + COL_W'(1);
               if (pix_last && state_ff == RHM_CLEAR) begin
                  col_in = col_last ? '0 : col_ff + COL_W'(1);
               end
            end
            if (state_ff == RHM_UPDATE) begin
               // track pixels below the rank value
               if (!half_ff) begin
                  if (op_addr < med_ff && below_ff != '0) below_in = below_ff - CNT_W'(1);
               end else begin
                  if (op_addr < med_ff) below_in = below_ff + CNT_W'(1);
               end
               // advance the column history
               if (op_last_upd) begin
                  for (int c = 0; c < WIDTH - 1; c++) begin
                     col_hist_in[c] = col_hist_ff[c + 1];
                  end
                  col_hist_in[WIDTH - 1] = fresh_ff;
               end
            end else if (op_last_clr) begin
               // window now holds zero pixels only
               for (int c = 0; c < WIDTH; c++) begin
                  for (int k = 0; k < WIDTH; k++) begin
                     col_hist_in[c][k] = '0;
                  end
               end
               med_in = '0;
               below_in = '0;
               seen_in = '0;
            end
         end
         RHM_WALK_START: begin
            if (go_down) begin
               if (med_ff != '0) begin
                  rd_en = 1'b1;
                  rd_addr = med_dn;
               end
            end else begin
               rd_en = 1'b1;
               rd_addr = med_ff;
            end
         end
         RHM_WALK_DOWN: begin
            med_in = med_dn;
            below_in = below_dn;
            if (dn_cont) begin
               rd_en = 1'b1;
               rd_addr = med_dn - BIN_W'(1);
            end
         end
         RHM_WALK_UP: begin
            if (up_cont) begin
               below_in = CNT_W'(up_sum);
               med_in = med_ff + BIN_W'(1);
               rd_en = 1'b1;
               rd_addr = med_ff + BIN_W'(1);
            end
         end
         RHM_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_med_in = PIX_W'(med_ff);
            end
         end
         default: begin
         end
      endcase

      // count warm-up columns
      if (walk_done && seen_ff != SEEN_W'(RADIUS)) seen_in = seen_ff + SEEN_W'(1);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RHM_INIT;
         init_addr_ff <= '0;
         col_ff <= '0;
         pix_ff <= '0;
         half_ff <= 1'b0;
         pend_ff <= 1'b0;
         med_ff <= '0;
         below_ff <= '0;
         seen_ff <= '0;
         th_ff <= TH_RESET;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < WIDTH; c++) begin
            for (int k = 0; k < WIDTH; k++) begin
               col_hist_ff[c][k] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         init_addr_ff <= init_addr_in;
         col_ff <= col_in;
         pix_ff <= pix_in;
         half_ff <= half_in;
         pend_ff <= pend_in;
         med_ff <= med_in;
         below_ff <= below_in;
         seen_ff <= seen_in;
         th_ff <= th_in;
         rsp_valid_ff <= rsp_valid_in;
         col_hist_ff <= col_hist_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_inc_ff <= pend_inc_in;
      fresh_ff <= fresh_in;
      rsp_med_ff <= rsp_med_in;
   end

   assign req_ready = (state_ff == RHM_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_median_out = rsp_med_ff;

endmodule

// File: verif/tb_running_histogram_median_filter.sv
module tb_running_histogram_median_filter;
   import rhm_pkg::*;

   localparam int BINS = BINS_DEFAULT;
   // longest column: row purge, update, a full walk over every bin, response load
   localparam int SETTLE_CYCLES = 400;

   typedef logic [PIX_W-1:0] column_type [WIDTH];

   // row styles for column content
   typedef enum int {
      COL_UNIFORM,
      COL_NEAR_BASE,
      COL_EXTREMES,
      COL_MIXED
   } column_style_type;

   // rows cut off by the image border
   typedef enum int {
      RIM_NONE,
      RIM_TOP_ONE,
      RIM_TOP_TWO,
      RIM_BOTTOM_ONE,
      RIM_BOTTOM_TWO
   } rim_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PIX_W-1:0] req_pix_0 = '0;
   logic [PIX_W-1:0] req_pix_1 = '0;
   logic [PIX_W-1:0] req_pix_2 = '0;
   logic [PIX_W-1:0] req_pix_3 = '0;
   logic [PIX_W-1:0] req_pix_4 = '0;
   logic req_row_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_median_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TH_W-1:0] csr_wdata = '0;

   // window model
   int unsigned bin_count [BINS];
   logic [PIX_W-1:0] window_cols [WIDTH][WIDTH];
   int unsigned rank_value;
   int unsigned below_rank;
   int unsigned cols_seen;
   logic [TH_W-1:0] rank_sel;

   logic [PIX_W-1:0] median_due [$];
   int errors = 0;
   int columns_sent = 0;
   int idle_pct = 0;
   int stall_left = 0;

   running_histogram_median_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pix_0     (req_pix_0),
      .req_pix_1     (req_pix_1),
      .req_pix_2     (req_pix_2),
      .req_pix_3     (req_pix_3),
      .req_pix_4     (req_pix_4),
      .req_row_start (req_row_start),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_median_out(rsp_median_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // reset the window to 25 zero pixels
   function automatic void clear_window();
      foreach (bin_count[b]) bin_count[b] = 0;
      bin_count[0] = AREA;
      foreach (window_cols[c, r]) window_cols[c][r] = '0;
      rank_value = 0;
      below_rank = 0;
      cols_seen = 0;
   endfunction

   // move the rank value to where at most the selected count lies below it
   function automatic void walk_rank();
      int unsigned th;
      th = (rank_sel > AREA - 1) ? AREA - 1 : rank_sel;
      if (below_rank > th) begin
         while (below_rank > th && rank_value > 0) begin
            rank_value--;
            below_rank -= bin_count[rank_value];
         end
      end else begin
         while (below_rank + bin_count[rank_value] <= th && rank_value < BINS - 1) begin
            below_rank += bin_count[rank_value];
            rank_value++;
         end
      end
   endfunction

   // slide the window by one column and queue the rank value that it yields after warm-up
   function automatic void slide_window(input column_type col, input logic row_start);
      logic [PIX_W-1:0] old_pix;
      if (row_start) clear_window();
      for (int k = 0; k < WIDTH; k++) begin
         old_pix = window_cols[0][k];
         if (bin_count[old_pix] > 0) bin_count[old_pix]--;
         if (old_pix < rank_value && below_rank > 0) below_rank--;
         bin_count[col[k]]++;
         if (col[k] < rank_value) below_rank++;
      end
      for (int c = 0; c < WIDTH - 1; c++) window_cols[c] = window_cols[c + 1];
      window_cols[WIDTH - 1] = col;
      walk_rank();
      if (cols_seen >= RADIUS) median_due.push_back(rank_value[PIX_W-1:0]);
      else cols_seen++;
   endfunction

   // check each returned word against the oldest expectation
   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (median_due.size() == 0) begin
            $error("median_out: expected none, actual %0d", rsp_median_out);
            errors++;
         end else begin
            want = median_due.pop_front();
            if (rsp_median_out !== want) begin
               $error("median_out: expected %0d, actual %0d", want, rsp_median_out);
               errors++;
            end
         end
      end
   end

   // stall the response side in random bursts
   always @(posedge clock) begin
      if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // drive one column word and hold it until accepted
   task automatic send_column(input column_type col, input logic row_start);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pix_0 <= col[0];
      req_pix_1 <= col[1];
      req_pix_2 <= col[2];
      req_pix_3 <= col[3];
      req_pix_4 <= col[4];
      req_row_start <= row_start;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      slide_window(col, row_start);
      columns_sent++;
   endtask

   // drop valid, drain expectations, let a column with no result finish
   task automatic settle_block();
      req_valid <= 1'b0;
      while (median_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_rank(input logic [TH_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      rank_sel = value;
   endtask

   function automatic logic [PIX_W-1:0] near_pix(input int base);
      int v;
      v = base + $urandom_range(0, 16) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[PIX_W-1:0];
   endfunction

   function automatic void make_column(input column_style_type style, input int base,
                                       input rim_type rim, output column_type col);
      for (int k = 0; k < WIDTH; k++) begin
         case (style)
            COL_UNIFORM: col[k] = PIX_W'($urandom_range(0, 255));
            COL_NEAR_BASE: col[k] = near_pix(base);
            COL_EXTREMES: col[k] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: col[k] = $urandom_range(0, 3) == 0 ? PIX_W'($urandom_range(0, 255))
                                                         : near_pix(base);
         endcase
      end
      // zero the rows outside the image
      case (rim)
         RIM_TOP_ONE: col[0] = '0;
         RIM_TOP_TWO: begin
            col[0] = '0;
            col[1] = '0;
         end
         RIM_BOTTOM_ONE: col[4] = '0;
         RIM_BOTTOM_TWO: begin
            col[3] = '0;
            col[4] = '0;
         end
         default: ;
      endcase
   endfunction

   task automatic send_row(input int len, input int pads, input logic start);
      column_style_type row_style;
      column_style_type col_style;
      rim_type rim;
      int base;
      column_type col;
      column_type pad;
      row_style = column_style_type'($urandom_range(0, 3));
      rim = $urandom_range(0, 2) == 0 ? rim_type'($urandom_range(1, 4)) : RIM_NONE;
      base = $urandom_range(0, 255);
      foreach (pad[k]) pad[k] = '0;
      for (int c = 0; c < len; c++) begin
         col_style = $urandom_range(0, 9) < 3 ? column_style_type'($urandom_range(0, 3))
                                                : row_style;
         make_column(col_style, base, rim, col);
         send_column(col, start && c == 0);
      end
      for (int p = 0; p < pads; p++) send_column(pad, 1'b0);
   endtask

   // columns before any row start filter against the zero window from reset
   task automatic test_before_row_start();
      column_type col;
      for (int c = 0; c < 3; c++) begin
         make_column(COL_UNIFORM, 0, RIM_NONE, col);
         send_column(col, 1'b0);
      end
   endtask

   // saturated and alternating pixels at the default median rank
   task automatic test_flat_row();
      column_type pad;
      foreach (pad[k]) pad[k] = '0;
      send_column('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1);
      send_column('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0);
      send_column('{8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b0);
      send_column('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0);
      send_column(pad, 1'b0);
      send_column(pad, 1'b0);
   endtask

   // lowest rank, highest rank, and a rank past the window that saturates
   task automatic test_rank_extremes();
      logic [TH_W-1:0] ranks [3];
      column_type col;
      column_type pad;
      ranks = '{5'd0, 5'd24, 5'd31};
      foreach (pad[k]) pad[k] = '0;
      foreach (ranks[i]) begin
         set_rank(ranks[i]);
         make_column(COL_EXTREMES, 0, RIM_NONE, col);
         send_column(col, 1'b1);
         make_column(COL_UNIFORM, 0, RIM_NONE, col);
         send_column(col, 1'b0);
         make_column(COL_UNIFORM, 0, RIM_NONE, col);
         send_column(col, 1'b0);
         send_column(pad, 1'b0);
      end
   endtask

   // mostly well-formed rows, some without pads, continuations and single columns
   task automatic test_random_rows();
      logic [TH_W-1:0] rank_plan [7];
      int kind;
      rank_plan = '{5'd12, 5'd0, 5'd24, 5'd31, 5'd0, 5'd0, 5'd12};
      rank_plan[4] = $urandom_range(0, 31);
      rank_plan[5] = $urandom_range(0, 31);
      for (int phase = 0; phase < 7; phase++) begin
         set_rank(rank_plan[phase]);
         while (columns_sent < 25 + (phase + 1) * 200) begin
            if (phase == 6) idle_pct = 0;
            else idle_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 30);
            kind = $urandom_range(0, 99);
            if (kind < 80) send_row($urandom_range(1, 16), 2, 1'b1);
            else if (kind < 90) send_row($urandom_range(1, 12), 0, 1'b1);
            else if (kind < 95) send_row($urandom_range(1, 8), 2, 1'b0);
            else send_row(1, 0, 1'b1);
         end
      end
   endtask

   initial begin
      clear_window();
      rank_sel = TH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 20;
      test_before_row_start();
      test_flat_row();
      test_rank_extremes();
      set_rank(TH_RESET);
      test_random_rows();
      idle_pct = 0;
      settle_block();
      if (errors == 0 && median_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // give up on a hung run
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: running_histogram_median_filter.f
src/rhm_pkg.sv
src/rhm_hist_ram.sv
src/running_histogram_median_filter.sv
verif/tb_running_histogram_median_filter.sv
